// File: hdl/lrn_pkg.sv
package lrn_pkg;

    localparam int SUM_BITS    = 37;
    localparam int CFG_BITS    = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SUM_BITS-1:0] SUM_MAX  = '1;
    localparam logic [31:0]         NORM_MAX = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_BIAS   = 2'd1,
        REG_ALPHA  = 2'd2,
        REG_BETA   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]  radius;
        logic [31:0] bias;
        logic [31:0] alpha;
        logic [15:0] beta;
    } lrn_cfg_t;

    typedef struct packed {
        logic last;
        logic sum_clip;
    } job_flags_t;

endpackage

// File: hdl/local_response_norm_top.sv
// Channel   | Dir | Handshake          | Contents
// s_        | in  | s_tvalid/s_tready  | tdata: sample; tlast: vector_end
// m_        | out | m_tvalid/m_tready  | tdata: normalized; tlast: last_of_vector;
//           |     |                    | tuser: clipped
// cfg_      | in  | cfg_we             | cfg_index selects register, cfg_wdata value
//
// One sample is accepted per cycle while streaming and the queue has room.
// A sample with tlast starts a flush of radius zero-filled window steps in
// the front end. A radius write re-sums the window over 2*MAX_RADIUS+1 entries;
// s_tready is low meanwhile. Results leave a six-stage arithmetic pipeline.
// Reset (aresetn, synchronous) clears the window, count and pipeline, and
// loads radius 5, bias 1.0, alpha 1.0, beta 0.5. A stall on m_ holds the
// back end; a four-entry queue lets the front keep taking samples.
module local_response_norm_top #(
    parameter int MAX_RADIUS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // [SAMPLE_BITS-1:0] normalized
    output logic                              m_tlast,
    output logic                              m_tuser,   // [0] clipped
    input  logic                              cfg_we,
    input  logic [lrn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrn_pkg::CFG_BITS-1:0]      cfg_wdata
);
    import lrn_pkg::*;

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int QW = SAMPLE_BITS + SUM_BITS + $bits(job_flags_t);

    lrn_cfg_t cfg_reg;
    logic     radius_wr;

    logic                          job_valid, q_full, q_valid, back_ready;
    logic signed [SAMPLE_BITS-1:0] job_sample, q_sample, out_data;
    logic [SUM_BITS-1:0]           job_sum, q_sum;
    job_flags_t                    job_flags, q_flags;
    logic [QW-1:0]                 q_in, q_out;

    // register writes; a radius write also restarts the window sum
    assign radius_wr = cfg_we && (cfg_reg_t'(cfg_index) == REG_RADIUS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.radius <= 4'd5;
            cfg_reg.bias   <= 32'd65536;
            cfg_reg.alpha  <= 32'd16777216;
            cfg_reg.beta   <= 16'd2048;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS: cfg_reg.radius <= cfg_wdata[3:0];
                REG_BIAS:   cfg_reg.bias   <= cfg_wdata;
                REG_ALPHA:  cfg_reg.alpha  <= cfg_wdata;
                REG_BETA:   cfg_reg.beta   <= cfg_wdata[15:0];
            endcase
        end
    end

    // front: window, running sum of squares, flush sequencing
    lrn_front #(
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .radius_wr  (radius_wr),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_end     (s_tlast),
        .job_valid  (job_valid),
        .job_space  (!q_full),
        .job_sample (job_sample),
        .job_sum    (job_sum),
        .job_flags  (job_flags)
    );

    // queue between front and back
    assign q_in = {job_flags, job_sum, job_sample};

    lrn_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (job_valid),
        .wr_data   (q_in),
        .full      (q_full),
        .rd_en     (back_ready),
        .rd_data   (q_out),
        .not_empty (q_valid)
    );

    assign q_sample = q_out[SAMPLE_BITS-1:0];
    assign q_sum    = q_out[SAMPLE_BITS +: SUM_BITS];
    assign q_flags  = q_out[QW-1 -: $bits(job_flags_t)];

    // back: norm, Mitchell log/exp power, scaling and saturation
    lrn_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (back_ready),
        .in_sample (q_sample),
        .in_sum    (q_sum),
        .in_flags  (q_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .out_last  (m_tlast),
        .out_clip  (m_tuser)
    );

    assign m_tdata = DW'($unsigned(out_data));

endmodule

// File: hdl/lrn_fifo.sv
module lrn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/lrn_front.sv
module lrn_front #(
    parameter int MAX_RADIUS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lrn_pkg::lrn_cfg_t             cfg,
    input  logic                          radius_wr,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_end,
    output logic                          job_valid,
    input  logic                          job_space,
    output logic signed [SAMPLE_BITS-1:0] job_sample,
    output logic [lrn_pkg::SUM_BITS-1:0]  job_sum,
    output lrn_pkg::job_flags_t           job_flags
);
    import lrn_pkg::*;

    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int IW    = $clog2(WIN);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int ACC_W = SQ_W + $clog2(WIN + 1);
    localparam int CW    = (ACC_W > SUM_BITS) ? ACC_W : SUM_BITS;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_RESUM = 3'b100
    } front_state_t;

    front_state_t                 state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] win_reg [WIN];
    logic signed [SAMPLE_BITS-1:0] win_next [WIN];
    logic signed [SAMPLE_BITS-1:0] win_sh [WIN];
    logic [SQ_W-1:0]              sq_reg [WIN];
    logic [SQ_W-1:0]              sq_next [WIN];
    logic [SQ_W-1:0]              sq_sh [WIN];
    logic [ACC_W-1:0]             sum_reg, sum_next;
    logic [4:0]                   count_reg, count_next;
    logic [4:0]                   f_reg, f_next;
    logic [IW-1:0]                rs_idx_reg, rs_idx_next;

    logic [RW-1:0]                r_eff;
    logic [IW-1:0]                two_r, rd_idx;
    logic signed [SAMPLE_BITS-1:0] push_val;
    logic signed [SQ_W-1:0]       sq_s;
    logic [SQ_W-1:0]              sq_rd;
    logic [ACC_W-1:0]             sum_step;
    logic [CW-1:0]                sum_c;
    logic [4:0]                   count_inc;
    logic                         step, emit, last;

    // clamp the radius to what the window holds
    assign r_eff  = ({1'b0, cfg.radius} > 5'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(cfg.radius);
    assign two_r  = IW'({r_eff, 1'b0});
    assign rd_idx = (state_reg == ST_RESUM) ? rs_idx_reg : two_r;
    assign sq_rd  = sq_reg[rd_idx];

    assign push_val = (state_reg == ST_RUN) ? in_sample : '0;
    assign sq_s     = push_val * push_val;
    assign sum_step = sum_reg + ACC_W'($unsigned(sq_s)) - ACC_W'(sq_rd);

    always_comb begin
        win_sh[0] = push_val;
        sq_sh[0]  = $unsigned(sq_s);
        for (int k = 1; k < WIN; k++) begin
            win_sh[k] = win_reg[k-1];
            sq_sh[k]  = sq_reg[k-1];
        end
    end

    assign count_inc = (count_reg == 5'd31) ? count_reg : count_reg + 5'd1;
    assign in_ready  = (state_reg == ST_RUN) && job_space;
    assign step      = ((state_reg == ST_RUN) && in_valid && job_space) ||
                       ((state_reg == ST_FLUSH) && job_space);

    always_comb begin
        if (state_reg == ST_RUN) begin
            emit = count_inc > 5'(r_eff);
            last = in_end && (r_eff == '0);
        end else begin
            emit = ({1'b0, count_reg} + {1'b0, f_reg}) > 6'(r_eff);
            last = (f_reg == 5'(r_eff));
        end
    end

    // saturate the sum of squares to its field width
    assign sum_c              = CW'(sum_step);
    assign job_valid          = step && emit && (state_reg != ST_RESUM);
    assign job_sample         = win_sh[IW'(r_eff)];
    assign job_flags.sum_clip = sum_c > CW'(SUM_MAX);
    assign job_flags.last     = last;
    assign job_sum            = job_flags.sum_clip ? SUM_MAX : sum_c[SUM_BITS-1:0];

    always_comb begin
        state_next  = state_reg;
        win_next    = win_reg;
        sq_next     = sq_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        f_next      = f_reg;
        rs_idx_next = rs_idx_reg;
        if (radius_wr) begin
            state_next  = ST_RESUM;
            rs_idx_next = '0;
            sum_next    = '0;
        end else begin
            unique case (state_reg)
                ST_RESUM: begin
                    if (rs_idx_reg <= two_r) begin
                        sum_next = sum_reg + ACC_W'(sq_rd);
                    end
                    rs_idx_next = rs_idx_reg + 1'b1;
                    if (rs_idx_reg == IW'(WIN - 1)) begin
                        state_next = ST_RUN;
                    end
                end
                ST_RUN, ST_FLUSH: begin
                    if (step) begin
                        win_next = win_sh;
                        sq_next  = sq_sh;
                        sum_next = sum_step;
                        if (state_reg == ST_RUN) begin
                            count_next = count_inc;
                            if (in_end && r_eff != '0) begin
                                state_next = ST_FLUSH;
                                f_next     = 5'd1;
                            end
                        end else begin
                            f_next = f_reg + 5'd1;
                        end
                        // end of vector: clear the window
                        if (last) begin
                            state_next = ST_RUN;
                            count_next = '0;
                            sum_next   = '0;
                            for (int k = 0; k < WIN; k++) begin
                                win_next[k] = '0;
                                sq_next[k]  = '0;
                            end
                        end
                    end
                end
                default: state_next = ST_RUN;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_RUN;
            sum_reg    <= '0;
            count_reg  <= '0;
            f_reg      <= '0;
            rs_idx_reg <= '0;
            for (int k = 0; k < WIN; k++) begin
                win_reg[k] <= '0;
                sq_reg[k]  <= '0;
            end
        end else begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            f_reg      <= f_next;
            rs_idx_reg <= rs_idx_next;
            win_reg    <= win_next;
            sq_reg     <= sq_next;
        end
    end

endmodule

// File: hdl/lrn_back.sv
module lrn_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lrn_pkg::lrn_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic [lrn_pkg::SUM_BITS-1:0]  in_sum,
    input  lrn_pkg::job_flags_t           in_flags,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_data,
    output logic                          out_last,
    output logic                          out_clip
);
    import lrn_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SUM_BITS + 16;
    localparam int NW = PW + 2;
    localparam int MW = SB + 17;

    logic en;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic signed [SB-1:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    job_flags_t        f1_reg;
    logic              l2_reg, l3_reg, l4_reg, l5_reg;
    logic              c2_reg, c3_reg, c4_reg, c5_reg;
    logic              z3_reg, z4_reg, z5_reg;
    logic [PW-1:0]     phi1_reg, plo1_reg;
    logic [31:0]       norm2_reg;
    logic signed [21:0] l16_3_reg;
    logic signed [38:0] prod4_reg;
    logic [MW-1:0]     mag5_reg;
    logic signed [11:0] sh5_reg;
    logic signed [SB-1:0] out_reg;
    logic              last_o_reg, clip_o_reg;

    // stage 2 logic
    logic [NW-1:0]     scaled, norm_w;
    logic              nsat;
    // stage 3 logic
    logic [4:0]        msb;
    logic [31:0]       normd;
    logic signed [5:0] expo;
    // stage 5 logic
    logic signed [38:0] negp;
    logic signed [26:0] e16;
    logic signed [10:0] ipart;
    logic [SB-1:0]     magx;
    // output stage logic
    logic [SB-1:0]     lim, res;
    logic [11:0]       rs;
    logic [MW-1:0]     rshift;
    logic              oclip;

    assign en       = !vo_reg || out_ready;
    assign in_ready = en;

    assign scaled = (NW'(phi1_reg) + NW'(plo1_reg >> 16)) >> 8;
    assign norm_w = NW'(cfg.bias) + scaled;
    assign nsat   = norm_w > NW'(NORM_MAX);

    always_comb begin
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (norm2_reg[i]) begin
                msb = 5'(i);
            end
        end
    end
    assign normd = norm2_reg << (5'd31 - msb);
    assign expo  = $signed({1'b0, msb}) - 6'sd16;

    assign negp  = -prod4_reg;
    assign e16   = negp[38:12];
    assign ipart = e16[26:16];
    assign magx  = x4_reg[SB-1] ? SB'(-x4_reg) : SB'(x4_reg);

    always_comb begin
        lim    = x5_reg[SB-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        rs     = 12'(-sh5_reg);
        rshift = mag5_reg >> rs;
        res    = '0;
        oclip  = c5_reg;
        if (z5_reg) begin
            oclip = 1'b1;
            res   = (x5_reg == '0) ? '0 : lim;
        end else if (!sh5_reg[11]) begin
            if (mag5_reg == '0) begin
                res = '0;
            end else if (sh5_reg >= 12'(SB)) begin
                res   = lim;
                oclip = 1'b1;
            end else if (mag5_reg > MW'(lim >> sh5_reg[10:0])) begin
                res   = lim;
                oclip = 1'b1;
            end else begin
                res = SB'(mag5_reg << sh5_reg[10:0]);
            end
        end else begin
            if (rshift > MW'(lim)) begin
                res   = lim;
                oclip = 1'b1;
            end else begin
                res = SB'(rshift);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vo_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: alpha * sum as two half-width products
            x1_reg   <= in_sample;
            f1_reg   <= in_flags;
            phi1_reg <= PW'(cfg.alpha[31:16]) * PW'(in_sum);
            plo1_reg <= PW'(cfg.alpha[15:0]) * PW'(in_sum);
            // stage 2: norm, saturated
            x2_reg    <= x1_reg;
            l2_reg    <= f1_reg.last;
            c2_reg    <= f1_reg.sum_clip || nsat;
            norm2_reg <= nsat ? NORM_MAX : norm_w[31:0];
            // stage 3: log2 of norm
            x3_reg    <= x2_reg;
            l3_reg    <= l2_reg;
            c3_reg    <= c2_reg;
            z3_reg    <= (norm2_reg == '0);
            l16_3_reg <= {expo, normd[30:15]};
            // stage 4: times beta
            x4_reg    <= x3_reg;
            l4_reg    <= l3_reg;
            c4_reg    <= c3_reg;
            z4_reg    <= z3_reg;
            prod4_reg <= $signed({1'b0, cfg.beta}) * l16_3_reg;
            // stage 5: exp2 mantissa times |x|
            x5_reg   <= x4_reg;
            l5_reg   <= l4_reg;
            c5_reg   <= c4_reg;
            z5_reg   <= z4_reg;
            mag5_reg <= MW'(magx) * MW'({1'b1, e16[15:0]});
            sh5_reg  <= 12'(ipart) - 12'sd16;
            // output: scale by 2^I, saturate, restore sign
            out_reg    <= x5_reg[SB-1] ? SB'(-res) : res;
            last_o_reg <= l5_reg;
            clip_o_reg <= oclip;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;
    assign out_last  = last_o_reg;
    assign out_clip  = clip_o_reg;

endmodule

// File: verif/local_response_norm_top_tb.sv
`timescale 1ns / 100ps

module local_response_norm_top_tb;
    import lrn_pkg::*;

    localparam int MAX_R    = 8;
    localparam int WIN_LEN  = 2 * MAX_R + 1;
    localparam int CNT_SAT  = 31;
    // pipeline plus flush and radius re-sum, with margin
    localparam int SETTLE   = 60;

    typedef struct {
        logic [15:0] value;
        bit          last;
        bit          clip;
    } norm_result_t;

    // one row of the directed stimulus
    typedef struct {
        int          cfg_set;   // configuration set applied before the row
        logic [15:0] sample;
        bit          vec_end;
        bit          typed;     // expected result written in by hand
        logic [15:0] exp_value;
        bit          exp_last;
        bit          exp_clip;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;      // [15:0] sample
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [15:0] normalized
    logic        m_tlast;
    logic        m_tuser;      // [0] clipped
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    logic [31:0] cfg_wdata;

    // predictor state
    logic signed [15:0] depth_win [WIN_LEN];
    int unsigned        chan_cnt;
    logic [3:0]         p_radius;
    logic [31:0]        p_bias;
    logic [31:0]        p_alpha;
    logic [15:0]        p_beta;

    norm_result_t expected_norms[$];
    norm_result_t step_norms[$];
    int           mismatches;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           rx_hold_cycles;

    local_response_norm_top #(
        .MAX_RADIUS (MAX_R),
        .SAMPLE_BITS(16)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Normalize the sample sitting r places back in the window.
    function automatic norm_result_t normalize_center(int unsigned r);
        norm_result_t o;
        longint x, mag_x, lim, a, frac, l16, e16, ipart, m, mag, sh, res;
        logic [63:0] sq_sum, scaled, norm;
        int msb;
        bit clip;
        clip   = 1'b0;
        x      = depth_win[r];
        mag_x  = (x < 0) ? -x : x;
        lim    = (x < 0) ? 32768 : 32767;
        sq_sum = 0;
        for (int k = 0; k <= 2 * r; k++) begin
            a      = depth_win[k];
            a      = (a < 0) ? -a : a;
            sq_sum = sq_sum + a * a;
            if (sq_sum > SUM_MAX) begin
                sq_sum = SUM_MAX;
                clip   = 1'b1;
            end
        end
        scaled = ((64'(p_alpha[31:16]) * sq_sum) +
                  ((64'(p_alpha[15:0]) * sq_sum) >> 16)) >> 8;
        norm = 64'(p_bias) + scaled;
        if (norm > 64'(NORM_MAX)) begin
            norm = 64'(NORM_MAX);
            clip = 1'b1;
        end
        if (norm == 0) begin
            clip = 1'b1;
            res  = (x == 0) ? 0 : lim;
        end else begin
            msb = 31;
            while (norm[msb] == 1'b0)
                msb--;
            frac = longint'(norm) - (longint'(1) << msb);
            if (msb >= 16)
                frac = frac >> (msb - 16);
            else
                frac = frac << (16 - msb);
            l16   = longint'(msb - 16) * 65536 + frac;
            e16   = (-(longint'(p_beta) * l16)) >>> 12;
            ipart = e16 >>> 16;
            m     = 65536 + (e16 - ipart * 65536);
            mag   = mag_x * m;
            sh    = ipart - 16;
            if (sh >= 0) begin
                if (mag == 0) begin
                    res = 0;
                end else if (sh >= 48 || mag > (lim >> sh)) begin
                    res  = lim;
                    clip = 1'b1;
                end else begin
                    res = mag << sh;
                end
            end else begin
                res = (-sh >= 64) ? 0 : (mag >> (-sh));
                if (res > lim) begin
                    res  = lim;
                    clip = 1'b1;
                end
            end
        end
        o.value = (x < 0) ? 16'(-res) : 16'(res);
        o.last  = 1'b0;
        o.clip  = clip;
        return o;
    endfunction

    function automatic void shift_in(logic signed [15:0] v);
        for (int i = WIN_LEN - 1; i > 0; i--)
            depth_win[i] = depth_win[i - 1];
        depth_win[0] = v;
    endfunction

    // Advance the predictor by one accepted sample; results land in step_norms.
    function automatic void predict_sample(logic [15:0] smp, bit vec_end);
        int unsigned r;
        r = (p_radius > MAX_R) ? MAX_R : p_radius;
        step_norms.delete();
        shift_in(smp);
        if (chan_cnt < CNT_SAT)
            chan_cnt++;
        if (chan_cnt > r)
            step_norms.push_back(normalize_center(r));
        if (vec_end) begin
            for (int unsigned f = 1; f <= r; f++) begin
                shift_in(16'sd0);
                if (chan_cnt + f > r)
                    step_norms.push_back(normalize_center(r));
            end
            if (step_norms.size() > 0)
                step_norms[step_norms.size() - 1].last = 1'b1;
            for (int i = 0; i < WIN_LEN; i++)
                depth_win[i] = '0;
            chan_cnt = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        norm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_norms.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = expected_norms.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("normalized %h, want %h", m_tdata, want.value));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_vector %b, want %b", m_tlast, want.last));
                if (m_tuser !== want.clip)
                    report_mismatch($sformatf("clipped %b, want %b", m_tuser, want.clip));
            end
        end
    end

    // Receiver: hold off for a counted stretch when asked, else stall at random.
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Drivers (every task starts and ends at a falling edge)
    // ---------------------------------------------------------------

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        case (idx)
            REG_RADIUS: p_radius = val[3:0];
            REG_BIAS:   p_bias   = val;
            REG_ALPHA:  p_alpha  = val;
            REG_BETA:   p_beta   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [3:0] r, logic [31:0] b, logic [31:0] al, logic [15:0] be);
        write_reg(REG_RADIUS, {28'd0, r});
        write_reg(REG_BIAS, b);
        write_reg(REG_ALPHA, al);
        write_reg(REG_BETA, {16'd0, be});
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Drop the input, wait for every expected result, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_norms.size() > 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Offer one sample; return once the transaction has happened.
    task automatic send_sample(logic [15:0] smp, bit vec_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= vec_end;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_sample(smp, vec_end);
        @(negedge aclk);
    endtask

    task automatic queue_predicted(logic [15:0] smp, bit vec_end);
        send_sample(smp, vec_end);
        foreach (step_norms[i])
            expected_norms.push_back(step_norms[i]);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(255));
            3: return 16'(-$urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1 << 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            queue_predicted(pick_sample(), i == len - 1);
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------

    // Set 0: radius 0 with zero bias and alpha, so every norm is zero and the
    // output goes full scale with the sign of the sample, or zero for a zero sample.
    stim_row_t dir_rows[] = '{
        '{0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b1},
        '{0, 16'h8000, 1'b0, 1'b1, 16'h8000, 1'b0, 1'b1},
        '{0, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1},
        '{0, 16'h0001, 1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b1},
        '{0, 16'hFFFF, 1'b1, 1'b1, 16'h8000, 1'b1, 1'b1},
        // reset-like setting: short vector flushes everything at the end
        '{1, 16'h0100, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{1, 16'hFF00, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0},
        '{1, 16'h0000, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0},
        // radius above limit, saturating alpha and beta
        '{2, 16'h7FFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{2, 16'h8000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{2, 16'h7FFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{2, 16'h1234, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0},
        // radius 8, full bias, beta zero: the norm factor is one
        '{3, 16'h8000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{3, 16'h7FFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{3, 16'h0001, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0},
        // radius 1 and a small bias
        '{4, 16'h0001, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{4, 16'h7FFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{4, 16'h8000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{4, 16'h0080, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0}
    };

    task automatic apply_set(int set_id);
        case (set_id)
            0: apply_cfg(4'd0, 32'd0, 32'd0, 16'd2048);
            1: apply_cfg(4'd5, 32'd65536, 32'd16777216, 16'd2048);
            2: apply_cfg(4'd15, 32'd1, 32'hFFFF_FFFF, 16'hFFFF);
            3: apply_cfg(4'd8, 32'hFFFF_FFFF, 32'd0, 16'd0);
            default: apply_cfg(4'd1, 32'h100, 32'h0100_0000, 16'h1000);
        endcase
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        int cur_set;
        int sent;
        norm_result_t typed_norm;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_RADIUS;
        cfg_wdata      = '0;
        mismatches     = 0;
        tx_idle_pct    = 29;
        rx_idle_pct    = 73;
        rx_hold_cycles = 0;
        chan_cnt       = 0;
        for (int i = 0; i < WIN_LEN; i++)
            depth_win[i] = '0;
        p_radius = 4'd5;
        p_bias   = 32'd65536;
        p_alpha  = 32'd16777216;
        p_beta   = 16'd2048;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(negedge aclk);

        // Walk the directed table; reconfigure only between vectors.
        cur_set = -1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_set != cur_set) begin
                drain_results();
                cur_set = dir_rows[i].cfg_set;
                apply_set(cur_set);
            end
            if (dir_rows[i].typed) begin
                send_sample(dir_rows[i].sample, dir_rows[i].vec_end);
                typed_norm.value = dir_rows[i].exp_value;
                typed_norm.last  = dir_rows[i].exp_last;
                typed_norm.clip  = dir_rows[i].exp_clip;
                expected_norms.push_back(typed_norm);
            end else begin
                queue_predicted(dir_rows[i].sample, dir_rows[i].vec_end);
            end
        end
        drain_results();

        // Random phases: two per idling mode, a fresh setting for each.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin tx_idle_pct = 29; rx_idle_pct = 73; end
                1: begin tx_idle_pct = 73; rx_idle_pct = 29; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (ph == 0)
                apply_cfg(4'd8, 32'd65536, 32'd16777216, 16'd2048);
            else
                apply_cfg(4'($urandom_range(15)), pick_word(), pick_word(),
                          16'($urandom));
            // hold the receiver off while samples keep coming to fill the block
            if (ph == 4)
                rx_hold_cycles = 300;
            sent = 0;
            while (sent < 54) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 32)
                                               : $urandom_range(20, 1);
                send_vector(len);
                sent += len;
            end
            drain_results();
        end

        foreach (expected_norms[i])
            report_mismatch($sformatf("missing result %h", expected_norms[i].value));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
